/* design/brb_pkg.sv */
// Package for the chunked circular byte buffer.
// Holds the item codes, the command queue entry and the back-end state type.
// Depends on nothing; every other design file but brb_ram uses it.
package brb_pkg;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        K_ADD  = 2'd0,
        K_PEEK = 2'd1,
        K_TAKE = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REFUSE = 2'd2
    } t_status;

    typedef struct packed {
        logic                 is_read;
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_SEND
    } t_back_state;

endpackage

/* design/brb_in_if.sv */
// Input channel of the byte buffer: valid, ready and one request item.
// Depends on brb_pkg for the field widths.
interface brb_in_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::KIND_W-1:0]    kind;
    logic [brb_pkg::BYTE_W-1:0]    data_byte;
    logic                          chunk_start;
    logic [brb_pkg::LEN_W-1:0]     chunk_length;

    modport source (output valid, kind, data_byte, chunk_start, chunk_length, input ready);
    modport sink   (input valid, kind, data_byte, chunk_start, chunk_length, output ready);
endinterface

/* design/brb_out_if.sv */
// Output channel of the byte buffer: valid, ready and one result item.
// Depends on brb_pkg for the field widths.
interface brb_out_if;
    logic                            valid;
    logic                            ready;
    logic [brb_pkg::BYTE_W-1:0]      out_byte;
    logic [brb_pkg::STATUS_W-1:0]    status;
    logic                            last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink   (input valid, out_byte, status, last, output ready);
endinterface

/* design/brb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* design/brb_queue.sv */
// Short command queue between the front end and the back end.
// Depends on brb_pkg for the command entry type.
module brb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output brb_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import brb_pkg::*;

    localparam int QA = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [QA-1:0] r_wr_ptr;
    logic [QA-1:0] r_rd_ptr;
    logic [QA:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QA+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
endmodule

/* design/brb_front.sv */
// Front end: accepts requests, keeps the ring pointers and chunk state,
// writes added bytes and queues status results and read commands.
// Depends on brb_pkg and brb_in_if.
module brb_front #(
    parameter int RING_DEPTH = 1024,
    parameter int MAX_TAKE   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    brb_in_if.sink                        i_in,
    input  logic                          i_queue_full,
    input  logic                          i_rd_done,
    output logic                          o_push,
    output brb_pkg::t_cmd                 o_cmd,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_pos,
    output logic                          o_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0] o_wr_addr,
    output logic [brb_pkg::BYTE_W-1:0]    o_wr_data
);
    import brb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = PW + LEN_W;

    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [LEN_W-1:0] r_add_left, n_add_left;
    logic             r_add_refused, n_add_refused;
    logic             r_busy, n_busy;
    logic [PW-1:0]    r_rd_pos, n_rd_pos;

    logic             accept;
    logic [PW:0]      diff;
    logic [PW-1:0]    stored;
    logic [PW-1:0]    free_space;
    logic [CW-1:0]    len_ext;
    logic [PW:0]      head_sum;
    logic [PW-1:0]    tail_inc;

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !i_queue_full && !r_busy;

    assign diff       = {1'b0, r_tail} + (PW+1)'(RING_DEPTH) - {1'b0, r_head};
    assign stored     = (diff >= (PW+1)'(RING_DEPTH)) ? PW'(diff - (PW+1)'(RING_DEPTH))
                                                      : diff[PW-1:0];
    assign free_space = PW'(RING_DEPTH - 1) - stored;
    assign len_ext    = {{PW{1'b0}}, i_in.chunk_length};
    assign head_sum   = {1'b0, r_head} + (PW+1)'(i_in.chunk_length);
    assign tail_inc   = (r_tail == PW'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_comb begin
        logic             refuse;
        logic [LEN_W-1:0] left_dec;
        n_head        = r_head;
        n_tail        = r_tail;
        n_add_left    = r_add_left;
        n_add_refused = r_add_refused;
        n_busy        = r_busy && !i_rd_done;
        n_rd_pos      = r_rd_pos;
        o_push        = 1'b0;
        o_cmd         = '{is_read: 1'b0, status: ST_ACCEPT, count: '0};
        o_wr_en       = 1'b0;
        refuse        = r_add_refused;
        left_dec      = r_add_left - 1'b1;
        if (accept) begin
            unique case (t_kind'(i_in.kind))
                K_ADD: begin
                    if (i_in.chunk_start && i_in.chunk_length == '0) begin
                        n_add_left    = '0;
                        n_add_refused = 1'b0;
                        o_push        = 1'b1;
                    end else if (i_in.chunk_start || r_add_left != '0) begin
                        if (i_in.chunk_start) begin
                            refuse   = (len_ext > {{LEN_W{1'b0}}, free_space});
                            left_dec = i_in.chunk_length - 1'b1;
                        end
                        n_add_refused = refuse;
                        n_add_left    = left_dec;
                        if (!refuse) begin
                            o_wr_en = 1'b1;
                            n_tail  = tail_inc;
                        end
                        if (left_dec == '0) begin
                            o_push        = 1'b1;
                            o_cmd.status  = refuse ? ST_REFUSE : ST_ACCEPT;
                            n_add_refused = 1'b0;
                        end
                    end
                end
                K_PEEK, K_TAKE: begin
                    o_push = 1'b1;
                    if (i_in.chunk_length == '0
                            || i_in.chunk_length > LEN_W'(MAX_TAKE)
                            || len_ext > {{LEN_W{1'b0}}, stored}) begin
                        o_cmd.status = ST_REFUSE;
                    end else begin
                        o_cmd.is_read = 1'b1;
                        o_cmd.status  = ST_DATA;
                        o_cmd.count   = COUNT_W'(i_in.chunk_length);
                        n_busy        = 1'b1;
                        n_rd_pos      = r_head;
                        if (t_kind'(i_in.kind) == K_TAKE) begin
                            n_head = (head_sum >= (PW+1)'(RING_DEPTH))
                                   ? PW'(head_sum - (PW+1)'(RING_DEPTH))
                                   : head_sum[PW-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_add_left    <= '0;
            r_add_refused <= 1'b0;
            r_busy        <= 1'b0;
        end else begin
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_add_left    <= n_add_left;
            r_add_refused <= n_add_refused;
            r_busy        <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos <= n_rd_pos;
    end

    assign o_rd_pos  = r_rd_pos;
    assign o_wr_addr = r_tail;
    assign o_wr_data = i_in.data_byte;
endmodule

/* design/brb_back.sv */
// Back end: takes commands from the queue, reads the ring for peek and take
// and drives the result channel from an output register.
// Depends on brb_pkg and brb_out_if.
module brb_back #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brb_pkg::t_cmd                 i_cmd,
    input  logic                          i_queue_empty,
    input  logic [$clog2(RING_DEPTH)-1:0] i_rd_pos,
    input  logic [brb_pkg::BYTE_W-1:0]    i_rd_data,
    output logic                          o_pop,
    output logic                          o_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0] o_rd_addr,
    output logic                          o_rd_done,
    brb_out_if.source                     o_out
);
    import brb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);

    t_back_state        r_state, n_state;
    logic [PW-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_is_read, n_is_read;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    t_status            r_status, n_status;
    logic               r_last, n_last;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_left    = r_left;
        n_is_read = r_is_read;
        n_byte    = r_byte;
        n_status  = r_status;
        n_last    = r_last;
        o_pop     = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_done = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop     = 1'b1;
                    n_is_read = i_cmd.is_read;
                    if (i_cmd.is_read) begin
                        n_pos   = i_rd_pos;
                        n_left  = i_cmd.count;
                        n_state = BK_READ;
                    end else begin
                        n_byte   = '0;
                        n_status = i_cmd.status;
                        n_last   = 1'b1;
                        n_state  = BK_SEND;
                    end
                end
            end
            BK_READ: begin
                o_rd_en = 1'b1;
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                n_byte   = i_rd_data;
                n_status = ST_DATA;
                n_last   = (r_left == COUNT_W'(1));
                n_state  = BK_SEND;
            end
            BK_SEND: begin
                if (o_out.ready) begin
                    if (r_is_read && r_left != COUNT_W'(1)) begin
                        n_left  = r_left - 1'b1;
                        n_pos   = (r_pos == PW'(RING_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                        n_state = BK_READ;
                    end else begin
                        o_rd_done = r_is_read;
                        n_state   = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_is_read <= n_is_read;
        r_byte    <= n_byte;
        r_status  <= n_status;
        r_last    <= n_last;
    end

    assign o_rd_addr      = r_pos;
    assign o_out.valid    = (r_state == BK_SEND);
    assign o_out.out_byte = r_byte;
    assign o_out.status   = r_status;
    assign o_out.last     = r_last;
endmodule

/* design/byte_ring_buffer_chunked.sv */
// Top level of the chunked circular byte buffer.
// Depends on brb_pkg, brb_in_if, brb_out_if, brb_ram, brb_queue, brb_front and brb_back.
//
// A ring of RING_DEPTH bytes holding up to RING_DEPTH-1 of them. Add-chunk bytes are
// taken one per cycle while the request port is ready and written to the ring as they
// arrive; a chunk that does not fit is refused whole and its status is queued on its final
// byte. A peek or take of N bytes is accepted as a single request, after which the request
// port stays stalled until its last byte has been delivered; each byte is read through the
// registered ring read into the output register. Status results pass through a four-entry
// command queue and then the output register before they appear. The ring contents need
// no clearing after reset.
module byte_ring_buffer_chunked #(
    parameter int RING_DEPTH = 1024,
    parameter int MAX_TAKE   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brb_in_if.sink    i_in,
    brb_out_if.source o_out
);
    import brb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);

    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    logic              rd_done;
    logic [PW-1:0]     rd_pos;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    brb_front #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAKE   (MAX_TAKE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .i_rd_done    (rd_done),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_rd_pos     (rd_pos),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    brb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    brb_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_queue_empty (queue_empty),
        .i_rd_pos      (rd_pos),
        .i_rd_data     (rd_data),
        .o_pop         (pop),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_rd_done     (rd_done),
        .o_out         (o_out)
    );
endmodule
